### design/tcw_pkg.sv
// Shared constants, codes and types for the text console cell writer.
// No dependencies; every other design file imports this package.
package tcw_pkg;

    // Grid geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int KEEP_COUNT = CELL_COUNT - COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);

    // Field widths of the item ports.
    localparam int OP_W     = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    // Character and attribute constants.
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'd32;
    localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'd15;

    // Opcodes of the input item.
    localparam logic [OP_W-1:0] OP_PRINT = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_TEXT_ATTR = 1'b0;

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Classified command kinds.
    typedef logic [2:0] cmd_kind_t;
    localparam cmd_kind_t CMD_NOP       = 3'd0;
    localparam cmd_kind_t CMD_PUT       = 3'd1;
    localparam cmd_kind_t CMD_NEWLINE   = 3'd2;
    localparam cmd_kind_t CMD_BACKSPACE = 3'd3;
    localparam cmd_kind_t CMD_CLEAR     = 3'd4;
    localparam cmd_kind_t CMD_READ      = 3'd5;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [CHAR_W-1:0]   char_code;
        logic [ADDR_W-1:0]   addr;
    } cmd_t;

endpackage

### design/tcw_front.sv
// Front part: input handshake and classification of each item into a command.
// Depends on tcw_pkg.
module tcw_front
    import tcw_pkg::*;
(
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    opcode,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic [INDEX_W-1:0] cell_index,
    input  logic               queue_full,
    input  logic               init_busy,
    output logic               push,
    output cmd_t               cmd
);

    // Nothing is taken while the grid is being cleared after reset.
    assign in_ready = !queue_full && !init_busy;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        cmd.kind      = CMD_NOP;
        cmd.char_code = char_code;
        cmd.addr      = ADDR_W'(cell_index);
        case (opcode)
            OP_PRINT:
            begin
                if (char_code == CHAR_NEWLINE)
                begin
                    cmd.kind = CMD_NEWLINE;
                end
                else if (char_code == CHAR_BACKSPACE)
                begin
                    cmd.kind = CMD_BACKSPACE;
                end
                else
                begin
                    cmd.kind = CMD_PUT;
                end
            end
            OP_CLEAR:
            begin
                cmd.kind = CMD_CLEAR;
            end
            OP_READ:
            begin
                // A read beyond the grid reports zeros and changes nothing.
                if (cell_index < INDEX_W'(CELL_COUNT))
                begin
                    cmd.kind = CMD_READ;
                end
            end
            default:
            begin
                cmd.kind = CMD_NOP;
            end
        endcase
    end

endmodule

### design/tcw_queue.sv
// Short command queue between the front and back parts.
// Depends on tcw_pkg for the command type and depth.
module tcw_queue
    import tcw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd,
    output logic full
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign full       = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### design/tcw_back.sv
// Back part: cell memory, cursor, scroll and clear sequencer, result register.
// Depends on tcw_pkg; takes commands from tcw_queue.
module tcw_back
    import tcw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [ATTR_W-1:0]   text_attr,
    input  logic                head_valid,
    input  cmd_t                head_cmd,
    output logic                pop,
    output logic                init_busy,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CURSOR_W-1:0] cursor_offset,
    output logic [CHAR_W-1:0]   read_char,
    output logic [ATTR_W-1:0]   read_attr
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_COPY  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_BLANK = 3'd4;

    localparam logic [ADDR_W-1:0] LAST_CELL      = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_START = ADDR_W'(KEEP_COUNT);
    localparam logic [ADDR_W-1:0] LAST_KEEP      = ADDR_W'(KEEP_COUNT - 1);
    localparam logic [COL_W-1:0]  LAST_COL       = COL_W'(COLUMNS - 1);

    logic [CELL_W-1:0] cell_mem [CELL_COUNT];
    logic [CELL_W-1:0] rdata_reg;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic                init_reg;
    logic                init_next;
    logic [ADDR_W-1:0]   cursor_reg;
    logic [ADDR_W-1:0]   cursor_next;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ADDR_W-1:0]   cnt_reg;
    logic [ADDR_W-1:0]   cnt_next;
    logic                pend_reg;
    logic                pend_next;
    logic [ADDR_W-1:0]   pend_addr_reg;
    logic [ADDR_W-1:0]   pend_addr_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CURSOR_W-1:0] cursor_out_reg;
    logic [CHAR_W-1:0]   read_char_reg;
    logic [ATTR_W-1:0]   read_attr_reg;

    logic                out_load;
    logic [CHAR_W-1:0]   load_char;
    logic [ATTR_W-1:0]   load_attr;
    logic                mem_we;
    logic [ADDR_W-1:0]   waddr;
    logic [CELL_W-1:0]   wdata;
    logic [ADDR_W-1:0]   raddr;
    logic [ATTR_W-1:0]   blank_attr;

    assign init_busy     = init_reg;
    assign out_valid     = out_valid_reg;
    assign cursor_offset = cursor_out_reg;
    assign read_char     = read_char_reg;
    assign read_attr     = read_attr_reg;

    // The clearing pass after reset uses the reset attribute.
    assign blank_attr = init_reg ? ATTR_RESET : text_attr;

    // A command starts only when the result register is free for its result.
    assign pop = (state_reg == ST_IDLE) && head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        cursor_next    = cursor_reg;
        col_next       = col_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        out_load       = 1'b0;
        load_char      = '0;
        load_attr      = '0;
        mem_we         = 1'b0;
        waddr          = cursor_reg;
        wdata          = {CHAR_SPACE, blank_attr};
        raddr          = head_cmd.addr;

        // Second half of a scroll copy: the row below lands one row up.
        if (pend_reg)
        begin
            mem_we = 1'b1;
            waddr  = pend_addr_reg;
            wdata  = rdata_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    case (head_cmd.kind)
                        CMD_PUT:
                        begin
                            mem_we = 1'b1;
                            waddr  = cursor_reg;
                            wdata  = {head_cmd.char_code, text_attr};
                            if (cursor_reg == LAST_CELL)
                            begin
                                cursor_next = LAST_ROW_START;
                                col_next    = '0;
                                cnt_next    = '0;
                                state_next  = ST_COPY;
                            end
                            else
                            begin
                                cursor_next = cursor_reg + 1'b1;
                                col_next    = (col_reg == LAST_COL) ? '0 : col_reg + 1'b1;
                                out_load    = 1'b1;
                            end
                        end
                        CMD_NEWLINE:
                        begin
                            col_next = '0;
                            if (cursor_reg >= LAST_ROW_START)
                            begin
                                cursor_next = LAST_ROW_START;
                                cnt_next    = '0;
                                state_next  = ST_COPY;
                            end
                            else
                            begin
                                cursor_next = cursor_reg + ADDR_W'(COLUMNS)
                                              - ADDR_W'(col_reg);
                                out_load    = 1'b1;
                            end
                        end
                        CMD_BACKSPACE:
                        begin
                            if (cursor_reg != '0)
                            begin
                                mem_we      = 1'b1;
                                waddr       = cursor_reg - 1'b1;
                                wdata       = {CHAR_SPACE, text_attr};
                                cursor_next = cursor_reg - 1'b1;
                                col_next    = (col_reg == '0) ? LAST_COL : col_reg - 1'b1;
                            end
                            out_load = 1'b1;
                        end
                        CMD_CLEAR:
                        begin
                            cursor_next = '0;
                            col_next    = '0;
                            cnt_next    = '0;
                            state_next  = ST_BLANK;
                        end
                        CMD_READ:
                        begin
                            raddr      = head_cmd.addr;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                out_load   = 1'b1;
                load_char  = rdata_reg[CELL_W-1:ATTR_W];
                load_attr  = rdata_reg[ATTR_W-1:0];
                state_next = ST_IDLE;
            end
            ST_COPY:
            begin
                raddr          = cnt_reg + ADDR_W'(COLUMNS);
                pend_next      = 1'b1;
                pend_addr_next = cnt_reg;
                if (cnt_reg == LAST_KEEP)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                cnt_next   = LAST_ROW_START;
                state_next = ST_BLANK;
            end
            ST_BLANK:
            begin
                mem_we = 1'b1;
                waddr  = cnt_reg;
                wdata  = {CHAR_SPACE, blank_attr};
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                    init_next  = 1'b0;
                    out_load   = !init_reg;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_BLANK;
            init_reg      <= 1'b1;
            cursor_reg    <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        if (out_load)
        begin
            cursor_out_reg <= CURSOR_W'(cursor_next);
            read_char_reg  <= load_char;
            read_attr_reg  <= load_attr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[waddr] <= wdata;
        end
        rdata_reg <= cell_mem[raddr];
    end

endmodule

### design/text_console_cell_writer.sv
// Text console cell writer: an 80 x 25 grid of character cells in one memory. After reset
// the block blanks the grid in a clearing pass and takes no item meanwhile. A print,
// newline or backspace that does not scroll is completed in the idle state, so such items
// stream at one per cycle while results are taken; a read passes through the ST_READ state
// because the cell memory has a registered read port. A print or newline that runs past
// the last cell scrolls, which copies 1920 cells through the single read and write port
// one per cycle and then blanks the last row. A clear rewrites all 2000 cells. A two-entry
// command queue lets items be accepted while a long command is still running.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
module text_console_cell_writer
    import tcw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     opcode,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [INDEX_W-1:0]  cell_index,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CURSOR_W-1:0] cursor_offset,
    output logic [CHAR_W-1:0]   read_char,
    output logic [ATTR_W-1:0]   read_attr
);

    logic [ATTR_W-1:0] text_attr_reg;
    logic              reg_hit;
    logic              queue_full;
    logic              init_busy;
    logic              push;
    cmd_t              push_cmd;
    logic              pop;
    logic              head_valid;
    cmd_t              head_cmd;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_TEXT_ATTR);
    assign prdata  = reg_hit ? PDATA_W'(text_attr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attr_reg <= ATTR_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            text_attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    tcw_front u_front
    (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .char_code  (char_code),
        .cell_index (cell_index),
        .queue_full (queue_full),
        .init_busy  (init_busy),
        .push       (push),
        .cmd        (push_cmd)
    );

    tcw_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .full       (queue_full)
    );

    tcw_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_attr     (text_attr_reg),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .init_busy     (init_busy),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cursor_offset (cursor_offset),
        .read_char     (read_char),
        .read_attr     (read_attr)
    );

`ifndef SYNTHESIS
    // A reported cursor always lies inside the grid.
    a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cursor_offset < CURSOR_W'(CELL_COUNT)))
        else $error("cursor outside the grid");

    // During the clearing pass after reset no item enters and no result leaves.
    a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> (!out_valid && !(in_valid && in_ready) && !pop))
        else $error("activity during the clearing pass");

    // The back part never takes a command from an empty queue.
    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("command taken from an empty queue");
`endif

endmodule
